@@ hdl/omd_pkg.sv @@
// Shared types, constants and the Manchester transition table for the OOK pulse decoder.
package omd_pkg;

    localparam int MAX_PULSES = 4096;
    localparam int CNT_W = 14;
    localparam int BIT_CAP_I = (2 * MAX_PULSES > 16383) ? 16383 : 2 * MAX_PULSES;
    localparam logic [CNT_W-1:0] BIT_CAP = CNT_W'(BIT_CAP_I);

    localparam int DUR_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [2:0] {
        CFG_SHORT_HIGH_MIN = 3'd0,
        CFG_SHORT_HIGH_MAX = 3'd1,
        CFG_LONG_HIGH_MIN  = 3'd2,
        CFG_LONG_HIGH_MAX  = 3'd3,
        CFG_SHORT_LOW_MIN  = 3'd4,
        CFG_SHORT_LOW_MAX  = 3'd5,
        CFG_LONG_LOW_MIN   = 3'd6,
        CFG_LONG_LOW_MAX   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_C0 = 2'd0,
        PH_C1 = 2'd1,
        PH_D0 = 2'd2,
        PH_D1 = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        SYM_SH  = 3'd0,
        SYM_LH  = 3'd1,
        SYM_SL  = 3'd2,
        SYM_LL  = 3'd3,
        SYM_END = 3'd4,
        SYM_UND = 3'd5
    } sym_t;

    typedef enum logic [2:0] {
        ACT_ERR  = 3'd0,
        ACT_NONE = 3'd1,
        ACT_E1   = 3'd2,
        ACT_E0   = 3'd3,
        ACT_END  = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        KIND_BIT  = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STEP_HI   = 2'd0,
        STEP_LO   = 2'd1,
        STEP_DONE = 2'd2
    } step_t;

    typedef struct packed {
        act_t   act;
        phase_t nxt;
    } trans_t;

    typedef struct packed {
        sym_t sym_hi;
        sym_t sym_lo;
        logic last;
    } item_t;

    function automatic trans_t lookup(phase_t ph, sym_t s);
        trans_t t;
        t.act = ACT_ERR;
        t.nxt = PH_C0;
        case (ph)
            PH_C0: begin
                if (s == SYM_SH) begin
                    t.act = ACT_E0;
                    t.nxt = PH_D1;
                end
            end
            PH_C1: begin
                if (s == SYM_SL) begin
                    t.act = ACT_E1;
                    t.nxt = PH_D0;
                end else if (s == SYM_END) begin
                    t.act = ACT_END;
                    t.nxt = PH_C0;
                end
            end
            PH_D0: begin
                if (s == SYM_SH) begin
                    t.act = ACT_NONE;
                    t.nxt = PH_C1;
                end else if (s == SYM_LH) begin
                    t.act = ACT_E0;
                    t.nxt = PH_D1;
                end
            end
            PH_D1: begin
                if (s == SYM_SL) begin
                    t.act = ACT_NONE;
                    t.nxt = PH_C0;
                end else if (s == SYM_LL) begin
                    t.act = ACT_E1;
                    t.nxt = PH_D0;
                end else if (s == SYM_END) begin
                    t.act = ACT_END;
                    t.nxt = PH_C0;
                end
            end
            default: begin
                t.act = ACT_ERR;
                t.nxt = PH_C0;
            end
        endcase
        return t;
    endfunction

endpackage

@@ hdl/omd_front.sv @@
// Front end: window registers and classification of each pulse into two symbols.
module omd_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [omd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [omd_pkg::DUR_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [omd_pkg::DUR_W-1:0]      high_ns,
    input  logic [omd_pkg::DUR_W-1:0]      low_ns,
    input  logic                           last_pulse,
    output logic                           f_valid,
    input  logic                           f_ready,
    output omd_pkg::item_t                 f_item
);
    import omd_pkg::*;

    logic [DUR_W-1:0] win_reg [8];
    logic             fv_reg, fv_next;
    item_t            item_reg, item_next;
    logic             s_acc;
    logic             in_sh, in_lh, in_sl, in_ll;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            win_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign in_sh = high_ns >= win_reg[CFG_SHORT_HIGH_MIN] && high_ns <= win_reg[CFG_SHORT_HIGH_MAX];
    assign in_lh = high_ns >= win_reg[CFG_LONG_HIGH_MIN] && high_ns <= win_reg[CFG_LONG_HIGH_MAX];
    assign in_sl = low_ns >= win_reg[CFG_SHORT_LOW_MIN] && low_ns <= win_reg[CFG_SHORT_LOW_MAX];
    assign in_ll = low_ns >= win_reg[CFG_LONG_LOW_MIN] && low_ns <= win_reg[CFG_LONG_LOW_MAX];

    assign s_tready = !fv_reg || f_ready;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        item_next = item_reg;
        if (s_acc) begin
            item_next.sym_hi = in_sh ? SYM_SH : (in_lh ? SYM_LH : SYM_UND);
            item_next.sym_lo = in_sl ? SYM_SL : (in_ll ? SYM_LL :
                               (last_pulse ? SYM_END : SYM_UND));
            item_next.last   = last_pulse;
        end
        fv_next = s_acc ? 1'b1 : (f_ready ? 1'b0 : fv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign f_valid = fv_reg;
    assign f_item  = item_reg;

endmodule

@@ hdl/omd_queue.sv @@
// Two-entry queue of classified pulses between front end and symbol machine.
module omd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  omd_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_pop,
    output omd_pkg::item_t rd_item
);
    import omd_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_item  = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

endmodule

@@ hdl/omd_back.sv @@
// Back end: Manchester machine, one symbol per unstalled cycle, to result register.
module omd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  omd_pkg::item_t                q_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [1:0]                    result_kind,
    output logic                          bit_value,
    output logic [omd_pkg::CNT_W-1:0]     bits_decoded,
    output logic                          last_of_run
);
    import omd_pkg::*;

    phase_t           phase_reg, phase_next;
    step_t            step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             skip_reg, skip_next;

    logic             mv_reg, mv_next;
    kind_t            kind_reg, kind_next;
    logic             bit_reg, bit_next;
    logic [CNT_W-1:0] oc_reg, oc_next;
    logic             ol_reg, ol_next;

    logic             go;
    logic             emit;
    sym_t             cur_sym;
    trans_t           t_cur, t_ahead;
    logic [CNT_W-1:0] cnt_inc;

    assign go      = q_valid && (!mv_reg || m_tready);
    assign cur_sym = (step_reg == STEP_HI) ? q_item.sym_hi : q_item.sym_lo;
    assign t_cur   = lookup(phase_reg, cur_sym);
    assign t_ahead = lookup(t_cur.nxt, q_item.sym_lo);
    assign cnt_inc = (cnt_reg < BIT_CAP) ? cnt_reg + 1'b1 : cnt_reg;

    // next state of the symbol machine
    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        skip_next  = skip_reg;
        if (go) begin
            if (skip_reg) begin
                if (q_item.last) begin
                    skip_next = 1'b0;
                end
            end else begin
                case (step_reg)
                    STEP_HI, STEP_LO: begin
                        case (t_cur.act)
                            ACT_ERR: begin
                                phase_next = PH_C0;
                                cnt_next   = '0;
                                step_next  = STEP_HI;
                                skip_next  = !q_item.last;
                            end
                            ACT_END: begin
                                phase_next = PH_C0;
                                cnt_next   = '0;
                                step_next  = STEP_HI;
                            end
                            ACT_E0, ACT_E1, ACT_NONE: begin
                                phase_next = t_cur.nxt;
                                if (t_cur.act != ACT_NONE) begin
                                    cnt_next = cnt_inc;
                                end
                                if (step_reg == STEP_HI) begin
                                    step_next = STEP_LO;
                                end else begin
                                    step_next = q_item.last ? STEP_DONE : STEP_HI;
                                end
                            end
                            default: begin
                                phase_next = PH_C0;
                            end
                        endcase
                    end
                    default: begin
                        phase_next = PH_C0;
                        cnt_next   = '0;
                        step_next  = STEP_HI;
                    end
                endcase
            end
        end
    end

    // queue pop and result register
    always_comb begin
        emit      = 1'b0;
        q_pop     = 1'b0;
        kind_next = kind_reg;
        bit_next  = bit_reg;
        oc_next   = oc_reg;
        ol_next   = ol_reg;
        if (go) begin
            if (skip_reg) begin
                q_pop = 1'b1;
            end else begin
                case (step_reg)
                    STEP_HI, STEP_LO: begin
                        case (t_cur.act)
                            ACT_ERR, ACT_END: begin
                                emit      = 1'b1;
                                q_pop     = 1'b1;
                                kind_next = (t_cur.act == ACT_ERR) ? KIND_FAIL : KIND_OK;
                                bit_next  = 1'b0;
                                oc_next   = cnt_reg;
                                ol_next   = 1'b1;
                            end
                            ACT_E0, ACT_E1: begin
                                emit      = 1'b1;
                                q_pop     = (step_reg == STEP_LO) && !q_item.last;
                                kind_next = KIND_BIT;
                                bit_next  = t_cur.act == ACT_E1;
                                oc_next   = cnt_inc;
                                if (step_reg == STEP_HI) begin
                                    ol_next = t_ahead.act == ACT_NONE && !q_item.last;
                                end else begin
                                    ol_next = !q_item.last;
                                end
                            end
                            default: begin
                                q_pop = (step_reg == STEP_LO) && !q_item.last;
                            end
                        endcase
                    end
                    default: begin
                        emit      = 1'b1;
                        q_pop     = 1'b1;
                        kind_next = KIND_OK;
                        bit_next  = 1'b0;
                        oc_next   = cnt_reg;
                        ol_next   = 1'b1;
                    end
                endcase
            end
        end
        mv_next = emit ? 1'b1 : (m_tready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_C0;
            step_reg  <= STEP_HI;
            cnt_reg   <= '0;
            skip_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        bit_reg  <= bit_next;
        oc_reg   <= oc_next;
        ol_reg   <= ol_next;
    end

    assign m_tvalid     = mv_reg;
    assign result_kind  = kind_reg;
    assign bit_value    = bit_reg;
    assign bits_decoded = oc_reg;
    assign last_of_run  = ol_reg;

endmodule

@@ hdl/ook_manchester_pulse_decoder.sv @@
// Path: an accepted pulse is classified into the front-end item register, written to the queue,
// then stepped by the back-end machine into its result register, high symbol before low symbol.
// The machine takes one step per symbol, an extra step for a last pulse with a separate status,
// and a single step for a pulse that faults on its high symbol or is swallowed after one.
// The single symbol machine in the back end sets the pace; a 2-entry queue decouples it.
// Reset: aresetn synchronous active low; clears windows, machine state, queue, output valid.
module ook_manchester_pulse_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] high_ns, [63:32] low_ns
    input  logic        s_tlast,   // last_pulse
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] bit_value, [14:1] bits_decoded, [15] zero
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // last_of_run
);
    import omd_pkg::*;

    logic             f_valid, f_ready;
    item_t            f_item;
    logic             q_valid, q_pop;
    item_t            q_item;
    logic             bit_value;
    logic [CNT_W-1:0] bits_decoded;

    omd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .high_ns    (s_tdata[31:0]),
        .low_ns     (s_tdata[63:32]),
        .last_pulse (s_tlast),
        .f_valid    (f_valid),
        .f_ready    (f_ready),
        .f_item     (f_item)
    );

    omd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    omd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .result_kind  (m_tuser),
        .bit_value    (bit_value),
        .bits_decoded (bits_decoded),
        .last_of_run  (m_tlast)
    );

    assign m_tdata = {1'b0, bits_decoded, bit_value};

endmodule
